@@ sv/hhfl_pkg.sv @@
package hhfl_pkg;

  // result kinds
  localparam logic [1:0] KIND_NAME  = 2'd0;
  localparam logic [1:0] KIND_VALUE = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  // error status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_NAME = 2'd1;
  localparam logic [1:0] ST_NO_COLON = 2'd2;
  localparam logic [1:0] ST_WS_LONG  = 2'd3;

  // header kinds
  localparam logic [2:0] HK_OTHER = 3'd0;

  // lexer phases
  localparam logic [1:0] PH_NAME  = 2'd0;
  localparam logic [1:0] PH_SKIP  = 2'd1;
  localparam logic [1:0] PH_VALUE = 2'd2;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;

  localparam int KNOWN_COUNT = 5;
  localparam logic [KNOWN_COUNT-1:0] KNOWN_ALL = '1;
  localparam logic [3:0] KNOWN_LEN [KNOWN_COUNT] = '{4'd10, 4'd4, 4'd14, 4'd2, 4'd15};

  // names padded to 16 characters, first character in the top byte
  localparam logic [127:0] K_CONNECTION = {"connection", 48'h0};
  localparam logic [127:0] K_HOST       = {"host", 96'h0};
  localparam logic [127:0] K_CLEN       = {"content-length", 16'h0};
  localparam logic [127:0] K_TE         = {"te", 112'h0};
  localparam logic [127:0] K_ACCLANG    = {"accept-language", 8'h0};

  typedef struct packed {
    logic in_ready;
    logic take;
    logic start_flush;
    logic emit_ws;
    logic emit_held;
  } hhfl_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic need_flush;
    logic flush_last;
  } hhfl_stat_t;

  function automatic logic [7:0] known_char(input logic [2:0] idx, input logic [3:0] pos);
    logic [127:0] s;
    unique case (idx)
      3'd0:    s = K_CONNECTION;
      3'd1:    s = K_HOST;
      3'd2:    s = K_CLEN;
      3'd3:    s = K_TE;
      3'd4:    s = K_ACCLANG;
      default: s = '0;
    endcase
    return s[8*(15 - int'(pos)) +: 8];
  endfunction

  function automatic logic is_token(input logic [7:0] c);
    logic r;
    r = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A) ||
        (c >= 8'h41 && c <= 8'h5A) ||
        c == 8'h21 || c == 8'h23 || c == 8'h24 || c == 8'h25 || c == 8'h26 ||
        c == 8'h27 || c == 8'h2A || c == 8'h2B || c == 8'h2D || c == 8'h2E ||
        c == 8'h5E || c == 8'h5F || c == 8'h60 || c == 8'h7C;
    return r;
  endfunction

  function automatic logic is_value(input logic [7:0] c);
    return (c >= 8'h21 && c <= 8'h7E) || c[7];
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB;
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? (c | 8'h20) : c;
  endfunction

endpackage

@@ sv/hhfl_ram.sv @@
module hhfl_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 32
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

@@ sv/hhfl_ctrl.sv @@
module hhfl_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  hhfl_pkg::hhfl_stat_t stat,
  output hhfl_pkg::hhfl_cmd_t  cmd
);
  import hhfl_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FLUSH = 2'd1;
  localparam logic [1:0] S_EMIT  = 2'd2;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.in_ready = stat.slot_free;
        cmd.take     = in_valid && stat.slot_free;
        if (cmd.take && stat.need_flush) begin
          cmd.start_flush = 1'b1;
          state_nxt       = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (stat.slot_free) begin
          cmd.emit_ws = 1'b1;
          if (stat.flush_last) begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (stat.slot_free) begin
          cmd.emit_held = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ sv/hhfl_dp.sv @@
module hhfl_dp #(
  parameter int NAME_MAX = 64,
  parameter int WS_MAX   = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  hhfl_pkg::hhfl_cmd_t  cmd,
  output hhfl_pkg::hhfl_stat_t stat,
  input  logic [7:0]           in_data_byte,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [1:0]           out_kind,
  output logic [7:0]           out_byte,
  output logic [1:0]           out_status,
  output logic [2:0]           out_header_kind,
  output logic                 out_last
);
  import hhfl_pkg::*;

  localparam int NLW = $clog2(NAME_MAX + 1);
  localparam int CW  = $clog2(WS_MAX + 1);
  localparam int AW  = $clog2(WS_MAX > 1 ? WS_MAX : 2);

  logic [1:0]             phase_r, phase_nxt;
  logic [NLW-1:0]         nl_r, nl_nxt;
  logic [KNOWN_COUNT-1:0] match_r, match_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [CW-1:0]          idx_r, idx_nxt, idx_inc;
  logic [7:0]             held_r, held_nxt;

  logic       ov_r, ov_nxt;
  logic [1:0] okind_r, okind_nxt;
  logic [7:0] obyte_r, obyte_nxt;
  logic [1:0] ostat_r, ostat_nxt;
  logic [2:0] ohk_r, ohk_nxt;
  logic       olast_r, olast_nxt;

  logic       in_val_phase;
  logic [7:0] lc;
  logic [2:0] hk_now;
  logic       ws_we;
  logic       ws_tab_rd;

  assign in_val_phase    = (phase_r == PH_SKIP) || (phase_r == PH_VALUE);
  assign lc              = to_lower(in_data_byte);
  assign idx_inc         = idx_r + CW'(1);

  assign stat.slot_free  = !ov_r || out_ready;
  assign stat.need_flush = in_val_phase && is_value(in_data_byte) && (cnt_r != '0);
  assign stat.flush_last = (idx_inc == cnt_r);

  // known header of the name taken so far, lowest index wins
  always_comb begin
    hk_now = HK_OTHER;
    for (int i = KNOWN_COUNT - 1; i >= 0; i--) begin
      if (match_r[i] && nl_r == NLW'(KNOWN_LEN[i])) begin
        hk_now = 3'(i + 1);
      end
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    nl_nxt    = nl_r;
    match_nxt = match_r;
    cnt_nxt   = cnt_r;
    held_nxt  = held_r;
    idx_nxt   = idx_r;
    ws_we     = 1'b0;
    ov_nxt    = out_ready ? 1'b0 : ov_r;
    okind_nxt = okind_r;
    obyte_nxt = obyte_r;
    ostat_nxt = ostat_r;
    ohk_nxt   = ohk_r;
    olast_nxt = olast_r;

    if (cmd.start_flush) begin
      held_nxt  = in_data_byte;
      idx_nxt   = '0;
      phase_nxt = PH_VALUE;
    end else if (cmd.emit_ws) begin
      idx_nxt   = idx_inc;
      ov_nxt    = 1'b1;
      okind_nxt = KIND_VALUE;
      obyte_nxt = ws_tab_rd ? CH_TAB : CH_SPACE;
      ostat_nxt = ST_OK;
      ohk_nxt   = HK_OTHER;
      olast_nxt = 1'b0;
    end else if (cmd.emit_held) begin
      cnt_nxt   = '0;
      ov_nxt    = 1'b1;
      okind_nxt = KIND_VALUE;
      obyte_nxt = held_r;
      ostat_nxt = ST_OK;
      ohk_nxt   = HK_OTHER;
      olast_nxt = 1'b1;
    end else if (cmd.take) begin
      // single result or none; defaults describe a done/error result
      obyte_nxt = '0;
      ostat_nxt = ST_OK;
      ohk_nxt   = HK_OTHER;
      olast_nxt = 1'b1;
      okind_nxt = KIND_ERROR;
      if (in_val_phase) begin
        if (is_ws(in_data_byte)) begin
          if (phase_r == PH_VALUE) begin
            if (cnt_r >= CW'(WS_MAX)) begin
              ov_nxt    = 1'b1;
              ostat_nxt = ST_WS_LONG;
            end else begin
              ws_we   = 1'b1;
              cnt_nxt = cnt_r + CW'(1);
            end
          end
        end else if (is_value(in_data_byte)) begin
          ov_nxt    = 1'b1;
          okind_nxt = KIND_VALUE;
          obyte_nxt = in_data_byte;
          phase_nxt = PH_VALUE;
        end else begin
          ov_nxt    = 1'b1;
          okind_nxt = KIND_DONE;
          ohk_nxt   = hk_now;
        end
      end else begin
        if (is_token(in_data_byte)) begin
          ov_nxt = 1'b1;
          if (nl_r >= NLW'(NAME_MAX)) begin
            ostat_nxt = ST_BAD_NAME;
          end else begin
            for (int i = 0; i < KNOWN_COUNT; i++) begin
              if (nl_r >= NLW'(KNOWN_LEN[i]) || known_char(3'(i), nl_r[3:0]) != lc) begin
                match_nxt[i] = 1'b0;
              end
            end
            nl_nxt    = nl_r + NLW'(1);
            okind_nxt = KIND_NAME;
            obyte_nxt = lc;
          end
        end else if (nl_r == '0) begin
          ov_nxt    = 1'b1;
          ostat_nxt = ST_BAD_NAME;
        end else if (in_data_byte == CH_COLON) begin
          phase_nxt = PH_SKIP;
        end else begin
          ov_nxt    = 1'b1;
          ostat_nxt = ST_NO_COLON;
        end
      end
      // done or error restarts the field
      if (ov_nxt && (okind_nxt == KIND_DONE || okind_nxt == KIND_ERROR)) begin
        phase_nxt = PH_NAME;
        nl_nxt    = '0;
        match_nxt = KNOWN_ALL;
        cnt_nxt   = '0;
      end
    end
  end

  hhfl_ram #(
    .WIDTH(1),
    .DEPTH(WS_MAX)
  ) u_ws_ram (
    .clk    (clk),
    .we     (ws_we),
    .waddr  (cnt_r[AW-1:0]),
    .wdata  (in_data_byte == CH_TAB),
    .raddr  (idx_nxt[AW-1:0]),
    .rdata_r(ws_tab_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_NAME;
      nl_r    <= '0;
      match_r <= KNOWN_ALL;
      cnt_r   <= '0;
      idx_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      nl_r    <= nl_nxt;
      match_r <= match_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_r  <= held_nxt;
    okind_r <= okind_nxt;
    obyte_r <= obyte_nxt;
    ostat_r <= ostat_nxt;
    ohk_r   <= ohk_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid       = ov_r;
  assign out_kind        = okind_r;
  assign out_byte        = obyte_r;
  assign out_status      = ostat_r;
  assign out_header_kind = ohk_r;
  assign out_last        = olast_r;

endmodule

@@ sv/http_header_field_lexer.sv @@
// http header field lexer: takes one header-line byte per transfer and emits
// lower-cased name bytes, value bytes, and a done result carrying the known
// header kind (connection, host, content-length, te, accept-language) or an
// error result with a status code. Bytes that give at most one result each
// stream at one per cycle while the result side keeps taking transfers; the
// single output register lets a new byte enter in the same cycle the previous
// result is taken. A value byte that follows held spaces/tabs first starts
// reading the held run back out of the store, whose read is registered, then
// sends each held blank and lastly the value byte itself through the output
// register; the input stalls meanwhile. Held whitespace lives in a small
// WS_MAX x 1 memory; it needs no clearing after reset since only written
// entries are ever read back.
module http_header_field_lexer #(
  parameter int NAME_MAX = 64,
  parameter int WS_MAX   = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_byte,
  output logic [1:0] out_status,
  output logic [2:0] out_header_kind,
  output logic       out_last
);
  import hhfl_pkg::*;

  hhfl_cmd_t  cmd;
  hhfl_stat_t stat;

  // sequencer: idle / flushing held whitespace / emitting the held value byte
  hhfl_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .stat    (stat),
    .cmd     (cmd)
  );

  // lexer state, name matcher, whitespace store and output register
  hhfl_dp #(
    .NAME_MAX(NAME_MAX),
    .WS_MAX  (WS_MAX)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_data_byte   (in_data_byte),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_kind       (out_kind),
    .out_byte       (out_byte),
    .out_status     (out_status),
    .out_header_kind(out_header_kind),
    .out_last       (out_last)
  );

  assign in_ready = cmd.in_ready;

  // no input transfer while the whitespace flush owns the output register
  a_no_take_in_flush: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !(cmd.emit_ws || cmd.emit_held))
    else $error("input taken during whitespace flush");

  // a flushed whitespace byte is never the last result of its input byte
  a_ws_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_ws |=> (out_valid && !out_last && out_kind == KIND_VALUE))
    else $error("flushed whitespace marked last");

  // the held value byte closes the flush as the last result
  a_held_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_held |=> (out_valid && out_last && out_kind == KIND_VALUE))
    else $error("held value byte not marked last");

  // name, done and error results always end their input byte
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != KIND_VALUE) |-> out_last)
    else $error("non-value result without last");

endmodule

@@ test/tb_http_header_field_lexer.sv @@
module tb_http_header_field_lexer;
  import hhfl_pkg::*;

  // block parameters, kept at the defaults of the lexer
  localparam int NAME_LIMIT = 64;
  localparam int WS_LIMIT   = 32;

  // run shape
  localparam int RANDOM_ITEMS   = 200;
  localparam int DRAIN_AT       = 150;
  localparam int LONG_HOLD      = 150;
  localparam int TAIL_CYCLES    = 60;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PRINT_CAP      = 100;

  // header kinds reported on a done result
  localparam logic [2:0] HK_CONNECTION      = 3'd1;
  localparam logic [2:0] HK_HOST            = 3'd2;
  localparam logic [2:0] HK_CONTENT_LENGTH  = 3'd3;
  localparam logic [2:0] HK_TE              = 3'd4;
  localparam logic [2:0] HK_ACCEPT_LANGUAGE = 3'd5;

  localparam logic [2:0] KNOWN_KIND [KNOWN_COUNT] = '{
    HK_CONNECTION, HK_HOST, HK_CONTENT_LENGTH, HK_TE, HK_ACCEPT_LANGUAGE
  };

  // token punctuation allowed in a field name
  localparam logic [7:0] NAME_PUNCT [14] = '{
    8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A,
    8'h2B, 8'h2D, 8'h2E, 8'h5E, 8'h5F, 8'h60, 8'h7C
  };

  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_DEL = 8'h7F;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [1:0] status;
    logic [2:0] hkind;
    logic       last;
  } lex_result_t;

  // one entry of the send queue: a byte, or a marker that waits for a full drain
  typedef struct packed {
    logic       drain;
    logic [7:0] data;
  } send_item_t;

  typedef enum logic [1:0] {RX_STEADY, RX_COIN, RX_MOSTLY, RX_PERIODIC} rx_mode_t;

  typedef enum logic [1:0] {
    FIELD_RANDOM, FIELD_LONG_NAME, FIELD_FULL_RUN, FIELD_OVER_RUN
  } field_shape_t;

  string known_names [KNOWN_COUNT] = '{
    "connection", "host", "content-length", "te", "accept-language"
  };

  logic       clk          = 1'b0;
  logic       rst_n        = 1'b0;
  logic       in_valid     = 1'b0;
  logic [7:0] in_data_byte = 8'h00;
  logic       out_ready    = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic [1:0] out_status;
  logic [2:0] out_header_kind;
  logic       out_last;

  http_header_field_lexer #(
    .NAME_MAX(NAME_LIMIT),
    .WS_MAX  (WS_LIMIT)
  ) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_byte   (in_data_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_byte       (out_byte),
    .out_status     (out_status),
    .out_header_kind(out_header_kind),
    .out_last       (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // lexer prediction: own copy of the lexer state
  // ---------------------------------------------------------------------------
  logic [1:0]          lex_phase;
  int                  name_len;
  logic [4:0]          known_match;
  logic [WS_LIMIT-1:0] held_tab;
  int                  held_count;

  lex_result_t expected_q [$];
  int unsigned mismatches = 0;

  function automatic logic is_name_char(input logic [7:0] c);
    logic hit;
    hit = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
          (c >= 8'h61 && c <= 8'h7A);
    foreach (NAME_PUNCT[p]) if (c == NAME_PUNCT[p]) hit = 1'b1;
    return hit;
  endfunction

  function automatic logic is_value_char(input logic [7:0] c);
    return (c >= 8'h21 && c <= 8'h7E) || (c >= 8'h80);
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

  // first known header still matching at its full length
  function automatic logic [2:0] kind_of_name();
    for (int k = 0; k < KNOWN_COUNT; k++) begin
      if (known_match[k] && name_len == known_names[k].len()) return KNOWN_KIND[k];
    end
    return HK_OTHER;
  endfunction

  task automatic lex_restart();
    lex_phase   = PH_NAME;
    name_len    = 0;
    known_match = KNOWN_ALL;
    held_count  = 0;
  endtask

  task automatic push_result(input logic [1:0] kind, input logic [7:0] data,
                             input logic [1:0] status, input logic [2:0] hkind);
    lex_result_t r;
    r.kind   = kind;
    r.data   = data;
    r.status = status;
    r.hkind  = hkind;
    r.last   = 1'b0;
    expected_q.push_back(r);
  endtask

  // works out the results of one accepted byte and queues them
  task automatic lex_byte(input logic [7:0] c);
    logic [7:0]  lc;
    lex_result_t tail_r;
    int          before_n;
    before_n = expected_q.size();
    if (lex_phase == PH_SKIP || lex_phase == PH_VALUE) begin
      if (is_blank(c)) begin
        // blanks right after the colon are skipped, inner ones are held back
        if (lex_phase == PH_VALUE) begin
          if (held_count >= WS_LIMIT) begin
            push_result(KIND_ERROR, 8'h00, ST_WS_LONG, HK_OTHER);
            lex_restart();
          end else begin
            held_tab[held_count] = (c == CH_TAB);
            held_count = held_count + 1;
          end
        end
      end else if (is_value_char(c)) begin
        for (int i = 0; i < held_count; i++) begin
          push_result(KIND_VALUE, held_tab[i] ? CH_TAB : CH_SPACE, ST_OK, HK_OTHER);
        end
        held_count = 0;
        push_result(KIND_VALUE, c, ST_OK, HK_OTHER);
        lex_phase = PH_VALUE;
      end else begin
        push_result(KIND_DONE, 8'h00, ST_OK, kind_of_name());
        lex_restart();
      end
    end else begin
      // name phase, the unused phase code lands here too
      if (is_name_char(c)) begin
        if (name_len >= NAME_LIMIT) begin
          push_result(KIND_ERROR, 8'h00, ST_BAD_NAME, HK_OTHER);
          lex_restart();
        end else begin
          lc = (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
          for (int k = 0; k < KNOWN_COUNT; k++) begin
            if (name_len >= known_names[k].len() || known_names[k][name_len] != lc)
              known_match[k] = 1'b0;
          end
          name_len = name_len + 1;
          push_result(KIND_NAME, lc, ST_OK, HK_OTHER);
        end
      end else if (name_len == 0) begin
        push_result(KIND_ERROR, 8'h00, ST_BAD_NAME, HK_OTHER);
        lex_restart();
      end else if (c == CH_COLON) begin
        lex_phase = PH_SKIP;
      end else begin
        push_result(KIND_ERROR, 8'h00, ST_NO_COLON, HK_OTHER);
        lex_restart();
      end
    end
    // mark the final result of this byte
    if (expected_q.size() > before_n) begin
      tail_r = expected_q.pop_back();
      tail_r.last = 1'b1;
      expected_q.push_back(tail_r);
    end
  endtask

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_CAP) $display("mismatch at %0t: %s", $time, msg);
    mismatches = mismatches + 1;
  endtask

  // ---------------------------------------------------------------------------
  // stimulus building
  // ---------------------------------------------------------------------------
  send_item_t send_q [$];
  int         loaded_items = 0;

  task automatic load_byte(input logic [7:0] b);
    send_item_t s;
    s.drain = 1'b0;
    s.data  = b;
    send_q.push_back(s);
    loaded_items = loaded_items + 1;
  endtask

  task automatic load_drain();
    send_item_t s;
    s.drain = 1'b1;
    s.data  = 8'h00;
    send_q.push_back(s);
  endtask

  task automatic load_text(input string s);
    for (int i = 0; i < s.len(); i++) load_byte(s[i]);
  endtask

  function automatic logic [7:0] rand_token();
    int unsigned pick;
    pick = $urandom_range(0, 75);
    if (pick < 10) return 8'h30 + 8'(pick);
    else if (pick < 36) return 8'h61 + 8'(pick - 10);
    else if (pick < 62) return 8'h41 + 8'(pick - 36);
    return NAME_PUNCT[pick - 62];
  endfunction

  function automatic logic [7:0] rand_value();
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(8'h21, 8'h7E));
    return 8'($urandom_range(8'h80, 8'hFF));
  endfunction

  function automatic logic [7:0] rand_blank();
    return ($urandom_range(0, 1) == 0) ? CH_SPACE : CH_TAB;
  endfunction

  // control bytes that close a value
  function automatic logic [7:0] rand_terminator();
    int unsigned pick;
    pick = $urandom_range(0, 31);
    if (pick == 31) return CH_DEL;
    if (pick >= 9) return 8'(pick + 1);
    return 8'(pick);
  endfunction

  task automatic load_name(input field_shape_t shape);
    int unsigned pick;
    int          len;
    logic [7:0]  c;
    pick = $urandom_range(0, 99);
    if (shape == FIELD_LONG_NAME) begin
      // one past the name limit
      for (int i = 0; i <= NAME_LIMIT; i++) load_byte(rand_token());
    end else if (pick < 40) begin
      // a known header with random letter case
      len = $urandom_range(0, KNOWN_COUNT - 1);
      for (int i = 0; i < known_names[len].len(); i++) begin
        c = known_names[len][i];
        if (c >= 8'h61 && c <= 8'h7A && $urandom_range(0, 1) == 1) c = c - 8'h20;
        load_byte(c);
      end
    end else if (pick < 85) begin
      len = $urandom_range(1, 8);
      for (int i = 0; i < len; i++) load_byte(rand_token());
    end else if (pick < 90) begin
      len = $urandom_range(NAME_LIMIT - 4, NAME_LIMIT + 2);
      for (int i = 0; i < len; i++) load_byte(rand_token());
    end
    // otherwise an empty name
  endtask

  task automatic load_field(input field_shape_t shape);
    int segs;
    int run;
    load_name(shape);
    if ($urandom_range(0, 9) != 0) load_byte(CH_COLON);
    else load_byte(8'($urandom_range(0, 255)));
    repeat ($urandom_range(0, 3)) load_byte(rand_blank());
    segs = $urandom_range(0, 5);
    if (shape == FIELD_FULL_RUN || shape == FIELD_OVER_RUN) begin
      // a full run of held blanks, then one more value byte or one more blank
      load_byte(rand_value());
      repeat (WS_LIMIT) load_byte(rand_blank());
      load_byte((shape == FIELD_FULL_RUN) ? rand_value() : rand_blank());
    end
    for (int s = 0; s < segs; s++) begin
      repeat ($urandom_range(1, 4)) load_byte(rand_value());
      if (s < segs - 1) begin
        run = ($urandom_range(0, 24) == 0) ? $urandom_range(WS_LIMIT - 2, WS_LIMIT + 2)
                                           : $urandom_range(1, 3);
        repeat (run) load_byte(rand_blank());
      end
    end
    // trailing blanks are dropped by the lexer
    if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 2)) load_byte(rand_blank());
    load_byte(rand_terminator());
  endtask

  task automatic load_noise();
    repeat ($urandom_range(1, 5)) load_byte(8'($urandom_range(0, 255)));
  endtask

  // ---------------------------------------------------------------------------
  // sender: bursts of transfers with random gaps, plus one full drain pause
  // ---------------------------------------------------------------------------
  send_item_t  send_head;
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned drain_wait;
  int unsigned items_taken;
  logic        idle_flag;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid     <= 1'b0;
      in_data_byte <= 8'h00;
      burst_left   <= 0;
      gap_left     <= 0;
      drain_wait   <= 0;
      items_taken  <= 0;
    end else begin
      if (in_valid && in_ready) items_taken <= items_taken + 1;
      if (!in_valid || in_ready) begin
        if (send_q.size() != 0 && send_q[0].drain) begin
          // hold back until every queued result has been taken
          in_valid <= 1'b0;
          if (drain_wait >= 2 && idle_flag) begin
            send_head  = send_q.pop_front();
            drain_wait <= 0;
          end else begin
            drain_wait <= drain_wait + 1;
          end
        end else if (gap_left != 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (send_q.size() != 0) begin
          send_head     = send_q.pop_front();
          in_valid     <= 1'b1;
          in_data_byte <= send_head.data;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: stall pattern that changes mode, plus long hold-offs
  // ---------------------------------------------------------------------------
  rx_mode_t    rx_mode;
  int unsigned rx_mode_left;
  int unsigned rx_hold;
  int unsigned rx_taken;
  logic [2:0]  rx_phase;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready    <= 1'b0;
      rx_mode      <= RX_STEADY;
      rx_mode_left <= 0;
      rx_hold      <= 0;
      rx_taken     <= 0;
      rx_phase     <= 3'd0;
    end else begin
      if (out_valid && out_ready) rx_taken <= rx_taken + 1;
      if (rx_hold != 0) begin
        out_ready <= 1'b0;
        rx_hold   <= rx_hold - 1;
      end else if (out_valid && out_ready && (rx_taken == 30 || rx_taken == 90)) begin
        // long hold-off: the lexer fills up and stalls its input
        out_ready <= 1'b0;
        rx_hold   <= LONG_HOLD;
      end else begin
        if (rx_mode_left == 0) begin
          rx_mode      <= rx_mode_t'($urandom_range(0, 3));
          rx_mode_left <= $urandom_range(16, 80);
        end else begin
          rx_mode_left <= rx_mode_left - 1;
        end
        rx_phase <= rx_phase + 3'd1;
        case (rx_mode)
          RX_STEADY: begin
            out_ready <= 1'b1;
          end
          RX_COIN: begin
            out_ready <= 1'($urandom_range(0, 1));
          end
          RX_MOSTLY: begin
            out_ready <= ($urandom_range(0, 3) != 0);
          end
          default: begin
            out_ready <= (rx_phase[1:0] != 2'b11);
          end
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: check result transfers, then predict from input transfers
  // ---------------------------------------------------------------------------
  lex_result_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      lex_restart();
      idle_flag <= 1'b1;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d byte %02h",
                                    out_kind, out_byte));
        end else begin
          want = expected_q.pop_front();
          if (out_kind !== want.kind)
            report_mismatch($sformatf("kind %0d, want %0d", out_kind, want.kind));
          if (out_byte !== want.data)
            report_mismatch($sformatf("byte %02h, want %02h", out_byte, want.data));
          if (out_status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", out_status, want.status));
          if (out_header_kind !== want.hkind)
            report_mismatch($sformatf("header kind %0d, want %0d",
                                      out_header_kind, want.hkind));
          if (out_last !== want.last)
            report_mismatch($sformatf("last %0d, want %0d", out_last, want.last));
        end
      end
      if (in_valid && in_ready) lex_byte(in_data_byte);
      idle_flag <= (expected_q.size() == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: cycles with no transfer on either side
  // ---------------------------------------------------------------------------
  int unsigned stall_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin
    while (stall_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  int unsigned total_items;
  int unsigned field_no;
  logic        drained;

  initial begin
    // directed: empty name
    load_byte(CH_COLON);
    // name then the lowest byte: missing colon
    load_byte(8'h61);
    load_byte(8'h00);
    // te with tab after the colon, top byte, held blank flushed, trailing tab dropped
    load_text("Te:");
    load_byte(CH_TAB);
    load_byte(8'hFF);
    load_byte(CH_SPACE);
    load_byte(8'h21);
    load_byte(CH_TAB);
    load_byte(CH_CR);
    // host with an empty value
    load_text("Host:");
    load_byte(CH_LF);
    // highest printable value byte, closed by delete
    load_text("X:~");
    load_byte(CH_DEL);
    // high byte where a colon should be
    load_byte(8'h71);
    load_byte(8'h80);

    // random fields; the first three force the name limit and the blank-run limit
    total_items = loaded_items + RANDOM_ITEMS;
    field_no    = 0;
    drained     = 1'b0;
    while (loaded_items < total_items) begin
      case (field_no)
        0: load_field(FIELD_LONG_NAME);
        1: load_field(FIELD_FULL_RUN);
        2: load_field(FIELD_OVER_RUN);
        default: begin
          if ($urandom_range(0, 9) == 0) load_noise();
          else load_field(FIELD_RANDOM);
        end
      endcase
      field_no = field_no + 1;
      if (!drained && loaded_items >= total_items - RANDOM_ITEMS + DRAIN_AT) begin
        load_drain();
        drained = 1'b1;
      end
    end
    total_items = loaded_items;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (!(items_taken == total_items && idle_flag)) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_q.size()));

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/hhfl_pkg.sv
sv/hhfl_ram.sv
sv/hhfl_ctrl.sv
sv/hhfl_dp.sv
sv/http_header_field_lexer.sv
test/tb_http_header_field_lexer.sv
